### rtl/mpjq_pkg.sv
// Package for the max-priority job queue.
// Holds field widths, operation and status codes and the scan-control word type.
// No dependencies.
`timescale 1ns / 1ps

package mpjq_pkg;

    // Field widths of one stored job, and of the occupancy count
    localparam int ID_W    = 16;
    localparam int PRI_W   = 8;
    localparam int ENTRY_W = ID_W + PRI_W;
    localparam int OCC_W   = 5;

    // Operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Control word from the sequencer to the max-scan unit
    typedef struct packed {
        logic take;   // a read word is presented this cycle
        logic first;  // it is entry zero: load unconditionally
    } scan_ctl_t;

endpackage

### rtl/mpjq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mpjq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/mpjq_maxscan.sv
// Shared compare unit: keeps the highest priority seen so far, oldest on ties.
// Depends on mpjq_pkg.
`timescale 1ns / 1ps

module mpjq_maxscan #(
    parameter int IDX_W = 5
) (
    input  logic                       clk,
    input  mpjq_pkg::scan_ctl_t        ctl,
    input  logic [mpjq_pkg::ID_W-1:0]  in_id,
    input  logic [mpjq_pkg::PRI_W-1:0] in_pri,
    input  logic [IDX_W-1:0]           in_idx,
    output logic [mpjq_pkg::ID_W-1:0]  best_id,
    output logic [mpjq_pkg::PRI_W-1:0] best_pri,
    output logic [IDX_W-1:0]           best_idx
);

    logic [mpjq_pkg::ID_W-1:0]  best_id_reg;
    logic [mpjq_pkg::PRI_W-1:0] best_pri_reg;
    logic [IDX_W-1:0]           best_idx_reg;
    logic                       load;

    // Strictly greater keeps the older entry among equals
    assign load = ctl.take && (ctl.first || (in_pri > best_pri_reg));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            best_id_reg  <= in_id;
            best_pri_reg <= in_pri;
            best_idx_reg <= in_idx;
        end
    end

    assign best_id  = best_id_reg;
    assign best_pri = best_pri_reg;
    assign best_idx = best_idx_reg;

endmodule

### rtl/max_priority_job_queue_top.sv
// Top level of the max-priority job queue: sequencer, job RAM, max-scan unit.
// Depends on mpjq_pkg, mpjq_ram and mpjq_maxscan.
`timescale 1ns / 1ps

// Usage
//   Command channel: a word (func, job_id, priority_req) is taken at a rising
//   edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with status, removed_job_id,
//   removed_priority and occupancy; the receiver cannot stall it.
// Sequence
//   Insert, and remove from an empty queue: result in the cycle after the
//   command; busy stays low, so a new command may follow at once.
//   Remove: busy is high while the sequencer scans the N held jobs through
//   the RAM read port, latches the winner and moves the later entries down
//   one place. The time this takes is set by the single RAM port pair.
// Reset
//   rst_n clears the job count and the sequencer; RAM contents are not
//   cleared, since only entries below the count are ever read.
module max_priority_job_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                func,
    input  logic [mpjq_pkg::ID_W-1:0]           job_id,
    input  logic [mpjq_pkg::PRI_W-1:0]          priority_req,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [mpjq_pkg::ID_W-1:0]           removed_job_id,
    output logic [mpjq_pkg::PRI_W-1:0]          removed_priority,
    output logic [mpjq_pkg::OCC_W-1:0]          occupancy
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SETUP = 4'b0100,
        ST_SHIFT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] ridx_reg, ridx_next;
    logic          rvalid_reg, rvalid_next;
    logic          done_reg, done_next;
    logic [1:0]    status_reg, status_next;
    logic [mpjq_pkg::ID_W-1:0]  rid_reg, rid_next;
    logic [mpjq_pkg::PRI_W-1:0] rpr_reg, rpr_next;
    logic [mpjq_pkg::OCC_W-1:0] occ_reg, occ_next;

    logic                          accept;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [mpjq_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [mpjq_pkg::ENTRY_W-1:0]  ram_rdata;
    logic [CW-1:0]                 ridx_m1;
    logic [CW-1:0]                 count_m1;
    mpjq_pkg::scan_ctl_t           scan_ctl;
    logic [mpjq_pkg::ID_W-1:0]     best_id;
    logic [mpjq_pkg::PRI_W-1:0]    best_pri;
    logic [CW-1:0]                 best_idx;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign ridx_m1  = ridx_reg - 1'b1;
    assign count_m1 = count_reg - 1'b1;

    // Job storage: {id, priority} per entry
    mpjq_ram #(
        .WIDTH (mpjq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Running maximum over the words read during the scan
    mpjq_maxscan #(
        .IDX_W (CW)
    ) u_maxscan (
        .clk      (clk),
        .ctl      (scan_ctl),
        .in_id    (ram_rdata[mpjq_pkg::ENTRY_W-1:mpjq_pkg::PRI_W]),
        .in_pri   (ram_rdata[mpjq_pkg::PRI_W-1:0]),
        .in_idx   (ridx_reg),
        .best_id  (best_id),
        .best_pri (best_pri),
        .best_idx (best_idx)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        ridx_next   = ridx_reg;
        rvalid_next = 1'b0;
        done_next   = 1'b0;
        status_next = status_reg;
        rid_next    = rid_reg;
        rpr_next    = rpr_reg;
        occ_next    = occ_reg;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[AW-1:0];
        ram_wdata   = {job_id, priority_req};
        ram_raddr   = ptr_reg[AW-1:0];
        scan_ctl    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == mpjq_pkg::FUNC_INSERT)
                    begin
                        done_next = 1'b1;
                        rid_next  = '0;
                        rpr_next  = '0;
                        if (count_reg >= DEPTH_C)
                        begin
                            status_next = mpjq_pkg::STATUS_FULL;
                            occ_next    = mpjq_pkg::OCC_W'(count_reg);
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            count_next  = count_reg + 1'b1;
                            status_next = mpjq_pkg::STATUS_OK;
                            occ_next    = mpjq_pkg::OCC_W'(count_next);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next   = 1'b1;
                        rid_next    = '0;
                        rpr_next    = '0;
                        status_next = mpjq_pkg::STATUS_EMPTY;
                        occ_next    = '0;
                    end
                    else
                    begin
                        ptr_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue reads of entries 0 .. count-1
                if (ptr_reg < count_reg)
                begin
                    rvalid_next = 1'b1;
                    ridx_next   = ptr_reg;
                    ptr_next    = ptr_reg + 1'b1;
                end
                // Compare each returned word
                if (rvalid_reg)
                begin
                    scan_ctl.take  = 1'b1;
                    scan_ctl.first = (ridx_reg == '0);
                    if (ridx_reg == count_m1)
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end

            ST_SETUP:
            begin
                rid_next   = best_id;
                rpr_next   = best_pri;
                ptr_next   = best_idx + 1'b1;
                state_next = ST_SHIFT;
            end

            ST_SHIFT:
            begin
                // Read entry i+1, write it to i on the next cycle
                if (ptr_reg < count_reg)
                begin
                    rvalid_next = 1'b1;
                    ridx_next   = ptr_reg;
                    ptr_next    = ptr_reg + 1'b1;
                end
                if (rvalid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ridx_m1[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                else if (ptr_reg >= count_reg)
                begin
                    count_next  = count_m1;
                    done_next   = 1'b1;
                    status_next = mpjq_pkg::STATUS_OK;
                    occ_next    = mpjq_pkg::OCC_W'(count_m1);
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
            done_reg   <= done_next;
        end
    end

    // Payload and pointer registers
    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        ridx_reg   <= ridx_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
        rpr_reg    <= rpr_next;
        occ_reg    <= occ_next;
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign removed_job_id   = rid_reg;
    assign removed_priority = rpr_reg;
    assign occupancy        = occ_reg;

`ifndef SYNTHESIS
    // A result never appears while a remove is still in progress
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word strobed while busy");

    // Job count never exceeds capacity
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("job count above capacity");

    // A remove on a non-empty queue starts the scan
    a_remove_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == mpjq_pkg::FUNC_REMOVE && count_reg != '0) |=> busy)
        else $error("remove did not start the scan");

    // A full report carries no job
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == mpjq_pkg::STATUS_FULL) |->
            (removed_job_id == '0 && removed_priority == '0))
        else $error("full report with nonzero job");
`endif

endmodule

### tb/sv/tb_max_priority_job_queue_top.sv
// Self-checking testbench for max_priority_job_queue_top: directed and random
// insert/remove words, checked against a shadow copy of the job array.
// Depends on mpjq_pkg and the max_priority_job_queue_top RTL.
`timescale 1ns / 1ps

module tb_max_priority_job_queue_top;

    localparam int DEPTH        = 16;
    localparam int RANDOM_WORDS = 1325;
    // give the tail margin beyond the longest remove
    localparam int TAIL_CYCLES  = 4 * DEPTH + 8;

    typedef struct packed {
        logic                       func;
        logic [mpjq_pkg::ID_W-1:0]  job_id;
        logic [mpjq_pkg::PRI_W-1:0] pri;
    } job_cmd_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic [mpjq_pkg::ID_W-1:0]  job_id;
        logic [mpjq_pkg::PRI_W-1:0] pri;
        logic [mpjq_pkg::OCC_W-1:0] occ;
    } job_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       func = mpjq_pkg::FUNC_INSERT;
    logic [mpjq_pkg::ID_W-1:0]  job_id = '0;
    logic [mpjq_pkg::PRI_W-1:0] priority_req = '0;
    logic                       busy;
    logic                       done;
    logic [1:0]                 status;
    logic [mpjq_pkg::ID_W-1:0]  removed_job_id;
    logic [mpjq_pkg::PRI_W-1:0] removed_priority;
    logic [mpjq_pkg::OCC_W-1:0] occupancy;

    job_cmd_t    words_pending[$];
    job_result_t results_due[$];

    // shadow of the job array, in arrival order
    logic [mpjq_pkg::ID_W-1:0]  shadow_ids[DEPTH];
    logic [mpjq_pkg::PRI_W-1:0] shadow_pri[DEPTH];
    int                         queued_jobs = 0;

    int error_count = 0;
    int burst_left  = 0;
    int gap_left    = 0;

    job_cmd_t    taken_word;
    job_result_t seen;
    job_result_t want;

    max_priority_job_queue_top #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .func             (func),
        .job_id           (job_id),
        .priority_req     (priority_req),
        .done             (done),
        .status           (status),
        .removed_job_id   (removed_job_id),
        .removed_priority (removed_priority),
        .occupancy        (occupancy)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Apply one word to the shadow queue and return the result it must give
    function automatic job_result_t queue_predict(input job_cmd_t cmd);
        job_result_t r;
        int          best;
        r = '0;
        if (cmd.func == mpjq_pkg::FUNC_INSERT)
        begin
            if (queued_jobs >= DEPTH)
            begin
                r.status = mpjq_pkg::STATUS_FULL;
            end
            else
            begin
                shadow_ids[queued_jobs] = cmd.job_id;
                shadow_pri[queued_jobs] = cmd.pri;
                queued_jobs++;
                r.status = mpjq_pkg::STATUS_OK;
            end
        end
        else if (queued_jobs == 0)
        begin
            r.status = mpjq_pkg::STATUS_EMPTY;
        end
        else
        begin
            // strictly greater keeps the oldest among equal priorities
            best = 0;
            for (int i = 1; i < queued_jobs; i++)
            begin
                if (shadow_pri[i] > shadow_pri[best])
                    best = i;
            end
            r.status = mpjq_pkg::STATUS_OK;
            r.job_id = shadow_ids[best];
            r.pri    = shadow_pri[best];
            for (int i = best; i + 1 < queued_jobs; i++)
            begin
                shadow_ids[i] = shadow_ids[i + 1];
                shadow_pri[i] = shadow_pri[i + 1];
            end
            queued_jobs--;
        end
        r.occ = mpjq_pkg::OCC_W'(queued_jobs);
        return r;
    endfunction

    task automatic add_insert(input logic [mpjq_pkg::ID_W-1:0] id,
                              input logic [mpjq_pkg::PRI_W-1:0] pri);
        job_cmd_t c;
        c.func   = mpjq_pkg::FUNC_INSERT;
        c.job_id = id;
        c.pri    = pri;
        words_pending.push_back(c);
    endtask

    // id and priority are don't-care on remove, so they carry noise
    task automatic add_remove();
        job_cmd_t c;
        c.func   = mpjq_pkg::FUNC_REMOVE;
        c.job_id = mpjq_pkg::ID_W'($urandom);
        c.pri    = mpjq_pkg::PRI_W'($urandom);
        words_pending.push_back(c);
    endtask

    function automatic logic [mpjq_pkg::PRI_W-1:0] pick_priority(input int style);
        logic [mpjq_pkg::PRI_W-1:0] p;
        case (style)
            0: p = mpjq_pkg::PRI_W'($urandom);
            1: p = mpjq_pkg::PRI_W'($urandom_range(0, 3));
            default:
            begin
                case ($urandom_range(0, 3))
                    0: p = 8'h00;
                    1: p = 8'h01;
                    2: p = 8'hFE;
                    default: p = 8'hFF;
                endcase
            end
        endcase
        return p;
    endfunction

    // Driver: bursts of words with random gaps, word held while busy
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            func         <= mpjq_pkg::FUNC_INSERT;
            job_id       <= '0;
            priority_req <= '0;
            burst_left   <= 0;
            gap_left     <= 0;
        end
        else
        begin
            // word taken at this edge
            if (start && !busy)
            begin
                taken_word = words_pending.pop_front();
                results_due.push_back(queue_predict(taken_word));
            end

            if (start && busy)
            begin
                // keep the word on the bus until it is taken
            end
            else if (gap_left > 0 || words_pending.size() == 0)
            begin
                start        <= 1'b0;
                func         <= 1'($urandom_range(0, 1));
                job_id       <= mpjq_pkg::ID_W'($urandom);
                priority_req <= mpjq_pkg::PRI_W'($urandom);
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                start        <= 1'b1;
                func         <= words_pending[0].func;
                job_id       <= words_pending[0].job_id;
                priority_req <= words_pending[0].pri;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Monitor: every done word is compared with the oldest expected result
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen.status = status;
            seen.job_id = removed_job_id;
            seen.pri    = removed_priority;
            seen.occ    = occupancy;
            if (results_due.size() == 0)
            begin
                flag_error($sformatf(
                    "result with none expected: status %0d id %h pri %h occ %0d",
                    seen.status, seen.job_id, seen.pri, seen.occ));
            end
            else
            begin
                want = results_due.pop_front();
                if (seen.status !== want.status)
                    flag_error($sformatf("status %0d, expected %0d", seen.status, want.status));
                if (seen.job_id !== want.job_id)
                    flag_error($sformatf("removed_job_id %h, expected %h",
                                         seen.job_id, want.job_id));
                if (seen.pri !== want.pri)
                    flag_error($sformatf("removed_priority %h, expected %h",
                                         seen.pri, want.pri));
                if (seen.occ !== want.occ)
                    flag_error($sformatf("occupancy %0d, expected %0d", seen.occ, want.occ));
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int op_style;
        int pri_style;
        int phase_len;
        int remove_pct;

        // directed: empty remove, extremes, tie on top priority
        add_remove();
        add_insert(16'h0000, 8'h00);
        add_insert(16'hFFFF, 8'hFF);
        add_insert(16'h1234, 8'hFF);
        add_remove();
        add_remove();
        add_remove();
        add_remove();
        // fill to capacity with many equal priorities, then overflow
        for (int i = 0; i < DEPTH; i++)
            add_insert(mpjq_pkg::ID_W'(16'hA500 + i), (i == 5 || i == 11) ? 8'hC0 : 8'h80);
        add_insert(16'h5A5A, 8'hFF);
        add_remove();

        // random phases: filling, draining, balanced
        while (words_pending.size() < RANDOM_WORDS + 26)
        begin
            op_style  = $urandom_range(0, 2);
            pri_style = $urandom_range(0, 2);
            phase_len = $urandom_range(16, 64);
            case (op_style)
                0: remove_pct = 15;
                1: remove_pct = 85;
                default: remove_pct = 50;
            endcase
            for (int k = 0; k < phase_len; k++)
            begin
                if ($urandom_range(0, 99) < remove_pct)
                    add_remove();
                else
                    add_insert(mpjq_pkg::ID_W'($urandom), pick_priority(pri_style));
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (words_pending.size() != 0)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (results_due.size() != 0)
            flag_error($sformatf("%0d results never arrived", results_due.size()));

        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("TIMEOUT: run did not complete");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
